>>> src/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, widths and saturation helpers for the segment clipping pipeline
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int ADDR_W    = 3;
	localparam int PROJ_W    = 50;
	localparam int SPAN_W    = 51;
	localparam int REM_W     = 52;
	localparam int FRAC_W    = 17;
	localparam int FRAC_SH   = 16;
	localparam int DIV_STEPS = 16;
	localparam int PX_W      = 36;
	localparam int SEP_W     = 49;

	localparam logic              REG_SPAN_EPS = 1'b0;
	localparam logic [FRAC_W-1:0] FRAC_ONE     = 17'h10000;
	localparam logic [15:0]       EPS_RESET    = 16'd1;

	typedef logic signed [31:0] coord_t;

	localparam coord_t SAT_MAX     = 32'sh7fffffff;
	localparam coord_t SAT_NEG_SYM = 32'sh80000001;
	localparam coord_t SAT_MIN     = 32'sh80000000;

	typedef struct packed {
		coord_t      b1x;
		coord_t      b1y;
		coord_t      b2x;
		coord_t      b2y;
		coord_t      a1x;
		coord_t      a1y;
		coord_t      nx;
		coord_t      ny;
		logic [30:0] ra;
		logic [30:0] rb;
		logic [15:0] lower_id;
		logic [15:0] upper_id;
		logic        clip_lo;
		logic        clip_hi;
	} carry_t;

	typedef struct packed {
		logic [REM_W-1:0]  den;
		logic [REM_W-1:0]  rem_lo;
		logic [REM_W-1:0]  rem_hi;
		logic [FRAC_W-1:0] q_lo;
		logic [FRAC_W-1:0] q_hi;
		logic              busy_lo;
		logic              busy_hi;
	} div_t;

	// clamp to +-(2^31 - 1)
	function automatic coord_t sat_sym(input logic signed [63:0] v);
		coord_t r;
		if (v > 64'sd2147483647) begin
			r = SAT_MAX;
		end else if (v < -64'sd2147483647) begin
			r = SAT_NEG_SYM;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// clamp to signed 32 bit
	function automatic coord_t sat_full(input logic signed [63:0] v);
		coord_t r;
		if (v > 64'sd2147483647) begin
			r = SAT_MAX;
		end else if (v < -64'sd2147483648) begin
			r = SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic coord_t diff_sat(input coord_t p, input coord_t q);
		logic signed [63:0] d;
		d = 64'(p) - 64'(q);
		return sat_sym(d);
	endfunction

	// one restoring step on both quotients
	function automatic div_t div_step(input div_t d);
		div_t             r;
		logic [REM_W-1:0] t;
		r = d;
		if (d.busy_lo) begin
			t = {d.rem_lo[REM_W-2:0], 1'b0};
			r.q_lo = {d.q_lo[FRAC_W-2:0], 1'b0};
			if (t >= d.den) begin
				t = t - d.den;
				r.q_lo[0] = 1'b1;
			end
			r.rem_lo = t;
		end
		if (d.busy_hi) begin
			t = {d.rem_hi[REM_W-2:0], 1'b0};
			r.q_hi = {d.q_hi[FRAC_W-2:0], 1'b0};
			if (t >= d.den) begin
				t = t - d.den;
				r.q_hi[0] = 1'b1;
			end
			r.rem_hi = t;
		end
		return r;
	endfunction

endpackage

>>> src/scc_div.sv
// ----------------------------------------------------------------------------
// scc_div
// Pipelined Q1.16 fraction divider, one quotient bit per stage, two quotients
// sharing one denominator; saturates to 0..1
// ----------------------------------------------------------------------------
module scc_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  scc_pkg::carry_t                      in_carry,
	input  logic signed [scc_pkg::SPAN_W-1:0]    in_num_lo,
	input  logic signed [scc_pkg::SPAN_W-1:0]    in_num_hi,
	input  logic signed [scc_pkg::SPAN_W-1:0]    in_den,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output scc_pkg::carry_t                      out_carry,
	output logic [scc_pkg::FRAC_W-1:0]           out_f_lo,
	output logic [scc_pkg::FRAC_W-1:0]           out_f_hi
);
	import scc_pkg::*;

	localparam int DEPTH = DIV_STEPS + 1;

	logic   v_s   [DEPTH];
	carry_t car_s [DEPTH];
	div_t   div_s [DEPTH];
	logic   go    [DEPTH+1];
	div_t   setup;

	always_comb begin
		setup     = '0;
		setup.den = {{(REM_W-SPAN_W){1'b0}}, in_den};
		if (in_num_lo <= 0) begin
			setup.q_lo = '0;
		end else if (in_num_lo >= in_den) begin
			setup.q_lo = FRAC_ONE;
		end else begin
			setup.rem_lo  = {{(REM_W-SPAN_W){1'b0}}, in_num_lo};
			setup.busy_lo = 1'b1;
		end
		if (in_num_hi <= 0) begin
			setup.q_hi = '0;
		end else if (in_num_hi >= in_den) begin
			setup.q_hi = FRAC_ONE;
		end else begin
			setup.rem_hi  = {{(REM_W-SPAN_W){1'b0}}, in_num_hi};
			setup.busy_hi = 1'b1;
		end
	end

	assign go[DEPTH] = out_ready;

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		assign go[k] = !v_s[k] || go[k+1];
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (go[k]) begin
					v_s[k] <= in_valid;
				end
			end
			always_ff @(posedge clk) begin
				if (go[k]) begin
					car_s[k] <= in_carry;
					div_s[k] <= setup;
				end
			end
		end else begin : g_step
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (go[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (go[k]) begin
					car_s[k] <= car_s[k-1];
					div_s[k] <= div_step(div_s[k-1]);
				end
			end
		end
	end

	assign in_ready  = go[0];
	assign out_valid = v_s[DEPTH-1];
	assign out_carry = car_s[DEPTH-1];
	assign out_f_lo  = div_s[DEPTH-1].q_lo;
	assign out_f_hi  = div_s[DEPTH-1].q_hi;

endmodule

>>> src/segment_clip_contacts.sv
// ----------------------------------------------------------------------------
// segment_clip_contacts
// Reference/incident edge clipping in 2D, Q16.16, giving a lower and an upper
// contact point for each overlapping segment pair
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | per item
//  ---------+-----------+----------------------+-------------------------------
//  input    | in        | in_valid / in_stall  | segments, normal, radii, ids
//  output   | out       | out_valid / out_stall| two items: lower, then upper
//  config   | in        | APB, pready tied high| span_epsilon at address 0
//
//  path: 4 projection stages, 17 divider stages, 8 clip/contact stages and
//  the output register, from input to the lower item
//  one input item per cycle enters while in_stall is low; an overlapping item
//  holds the output register until its upper item is taken, and no new item
//  enters it before then; pairs without overlap are dropped at stage 4
//  reset clears all valid bits and sets span_epsilon to 1
//  a stall moves back through full stages only; bubbles are squeezed out
// ----------------------------------------------------------------------------
module segment_clip_contacts (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [scc_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [63:0]                    ref_start,
	input  logic [63:0]                    ref_end,
	input  logic [63:0]                    inc_start,
	input  logic [63:0]                    inc_end,
	input  logic [63:0]                    contact_normal,
	input  logic [30:0]                    radius_ref,
	input  logic [30:0]                    radius_inc,
	input  logic [15:0]                    lower_id,
	input  logic [15:0]                    upper_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [63:0]                    contact_point,
	output logic signed [31:0]             separation,
	output logic [15:0]                    contact_id,
	output logic                           last_point
);
	import scc_pkg::*;

	// configuration
	logic [15:0] span_eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_eps_q <= EPS_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_SPAN_EPS) begin
			span_eps_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_SPAN_EPS) ? {16'd0, span_eps_q} : 32'd0;

	// stage control
	logic go_s1, go_s2, go_s3, go_s4;
	logic go_s5, go_s6, go_s7, go_s8, go_s9, go_s10, go_s11, go_s12, go_out;
	logic v_s1, v_s2, v_s3, v_s4;
	logic v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic div_in_ready, div_out_valid;
	logic out_valid_q, out_sel_q;

	assign go_out = !out_valid_q || (out_sel_q && !out_stall);
	assign go_s12 = !v_s12 || go_out;
	assign go_s11 = !v_s11 || go_s12;
	assign go_s10 = !v_s10 || go_s11;
	assign go_s9  = !v_s9 || go_s10;
	assign go_s8  = !v_s8 || go_s9;
	assign go_s7  = !v_s7 || go_s8;
	assign go_s6  = !v_s6 || go_s7;
	assign go_s5  = !v_s5 || go_s6;
	assign go_s4  = !v_s4 || div_in_ready;
	assign go_s3  = !v_s3 || go_s4;
	assign go_s2  = !v_s2 || go_s3;
	assign go_s1  = !v_s1 || go_s2;
	assign in_stall = !go_s1;

	// stage 1: saturated differences
	carry_t car_in;
	carry_t car_s1, car_s2, car_s3, car_s4;
	coord_t a2x_in, a2y_in;
	coord_t dax_s1, day_s1, d1x_s1, d1y_s1, d2x_s1, d2y_s1;
	logic signed [32:0] tx_s1;
	coord_t ty_s1;

	always_comb begin
		car_in          = '0;
		car_in.a1x      = ref_start[63:32];
		car_in.a1y      = ref_start[31:0];
		car_in.b1x      = inc_start[63:32];
		car_in.b1y      = inc_start[31:0];
		car_in.b2x      = inc_end[63:32];
		car_in.b2y      = inc_end[31:0];
		car_in.nx       = contact_normal[63:32];
		car_in.ny       = contact_normal[31:0];
		car_in.ra       = radius_ref;
		car_in.rb       = radius_inc;
		car_in.lower_id = lower_id;
		car_in.upper_id = upper_id;
		a2x_in          = ref_end[63:32];
		a2y_in          = ref_end[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (go_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			car_s1 <= car_in;
			dax_s1 <= diff_sat(a2x_in, car_in.a1x);
			day_s1 <= diff_sat(a2y_in, car_in.a1y);
			d1x_s1 <= diff_sat(car_in.b1x, car_in.a1x);
			d1y_s1 <= diff_sat(car_in.b1y, car_in.a1y);
			d2x_s1 <= diff_sat(car_in.b2x, car_in.a1x);
			d2y_s1 <= diff_sat(car_in.b2y, car_in.a1y);
			tx_s1  <= -33'(car_in.ny);
			ty_s1  <= car_in.nx;
		end
	end

	// stage 2: tangent products
	logic signed [64:0] pax_s2, pay_s2, p1x_s2, p1y_s2, p2x_s2, p2y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (go_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2) begin
			car_s2 <= car_s1;
			pax_s2 <= 65'(dax_s1) * 65'(tx_s1);
			pay_s2 <= 65'(day_s1) * 65'(ty_s1);
			p1x_s2 <= 65'(d1x_s1) * 65'(tx_s1);
			p1y_s2 <= 65'(d1y_s1) * 65'(ty_s1);
			p2x_s2 <= 65'(d2x_s1) * 65'(tx_s1);
			p2y_s2 <= 65'(d2y_s1) * 65'(ty_s1);
		end
	end

	// stage 3: projections
	logic signed [65:0] sum_a, sum_1, sum_2;
	logic signed [PROJ_W-1:0] upper1_s3, upper2_s3, lower2_s3;

	always_comb begin
		sum_a = 66'(pax_s2) + 66'(pay_s2);
		sum_1 = 66'(p1x_s2) + 66'(p1y_s2);
		sum_2 = 66'(p2x_s2) + 66'(p2y_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (go_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s3) begin
			car_s3    <= car_s2;
			upper1_s3 <= PROJ_W'(sum_a >>> FRAC_SH);
			upper2_s3 <= PROJ_W'(sum_1 >>> FRAC_SH);
			lower2_s3 <= PROJ_W'(sum_2 >>> FRAC_SH);
		end
	end

	// stage 4: overlap test, span and numerators
	logic overlap, wide;
	logic signed [SPAN_W-1:0] span, num_lo, num_hi;
	logic signed [SPAN_W-1:0] span_s4, num_lo_s4, num_hi_s4;
	carry_t car_next4;

	always_comb begin
		overlap   = !(upper2_s3 < 0 || upper1_s3 < lower2_s3);
		span      = SPAN_W'(upper2_s3) - SPAN_W'(lower2_s3);
		num_lo    = -SPAN_W'(lower2_s3);
		num_hi    = SPAN_W'(upper1_s3) - SPAN_W'(lower2_s3);
		wide      = span > $signed({{(SPAN_W-16){1'b0}}, span_eps_q});
		car_next4 = car_s3;
		car_next4.clip_lo = (lower2_s3 < 0) && wide;
		car_next4.clip_hi = (upper2_s3 > upper1_s3) && wide;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (go_s4) begin
			v_s4 <= v_s3 && overlap;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s4) begin
			car_s4    <= car_next4;
			span_s4   <= span;
			num_lo_s4 <= num_lo;
			num_hi_s4 <= num_hi;
		end
	end

	// interpolation factors
	carry_t div_carry;
	logic [FRAC_W-1:0] f_lo, f_hi;

	scc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.in_carry  (car_s4),
		.in_num_lo (num_lo_s4),
		.in_num_hi (num_hi_s4),
		.in_den    (span_s4),
		.out_valid (div_out_valid),
		.out_ready (go_s5),
		.out_carry (div_carry),
		.out_f_lo  (f_lo),
		.out_f_hi  (f_hi)
	);

	// stage 5: lerp products
	carry_t car_s5, car_s6, car_s7, car_s8, car_s9, car_s10, car_s11, car_s12;
	logic signed [32:0] ldx, ldy;
	logic signed [50:0] plx_s5, ply_s5, phx_s5, phy_s5;

	always_comb begin
		ldx = 33'(div_carry.b1x) - 33'(div_carry.b2x);
		ldy = 33'(div_carry.b1y) - 33'(div_carry.b2y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (go_s5) begin
			v_s5 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s5) begin
			car_s5 <= div_carry;
			plx_s5 <= 51'(ldx) * 51'($signed({1'b0, f_lo}));
			ply_s5 <= 51'(ldy) * 51'($signed({1'b0, f_lo}));
			phx_s5 <= 51'(ldx) * 51'($signed({1'b0, f_hi}));
			phy_s5 <= 51'(ldy) * 51'($signed({1'b0, f_hi}));
		end
	end

	// stage 6: clipped points
	logic signed [PX_W-1:0] px0_s6, py0_s6, px1_s6, py1_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (go_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s6) begin
			car_s6 <= car_s5;
			px0_s6 <= car_s5.clip_lo ? PX_W'(car_s5.b2x) + PX_W'(plx_s5 >>> FRAC_SH)
				: PX_W'(car_s5.b2x);
			py0_s6 <= car_s5.clip_lo ? PX_W'(car_s5.b2y) + PX_W'(ply_s5 >>> FRAC_SH)
				: PX_W'(car_s5.b2y);
			px1_s6 <= car_s5.clip_hi ? PX_W'(car_s5.b2x) + PX_W'(phx_s5 >>> FRAC_SH)
				: PX_W'(car_s5.b1x);
			py1_s6 <= car_s5.clip_hi ? PX_W'(car_s5.b2y) + PX_W'(phy_s5 >>> FRAC_SH)
				: PX_W'(car_s5.b1y);
		end
	end

	// stage 7: offsets from reference start
	logic signed [PX_W-1:0] px0_s7, py0_s7, px1_s7, py1_s7;
	coord_t ex0_s7, ey0_s7, ex1_s7, ey1_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (go_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s7) begin
			car_s7 <= car_s6;
			px0_s7 <= px0_s6;
			py0_s7 <= py0_s6;
			px1_s7 <= px1_s6;
			py1_s7 <= py1_s6;
			ex0_s7 <= sat_sym(64'(px0_s6) - 64'(car_s6.a1x));
			ey0_s7 <= sat_sym(64'(py0_s6) - 64'(car_s6.a1y));
			ex1_s7 <= sat_sym(64'(px1_s6) - 64'(car_s6.a1x));
			ey1_s7 <= sat_sym(64'(py1_s6) - 64'(car_s6.a1y));
		end
	end

	// stage 8: normal products
	logic signed [PX_W-1:0] px0_s8, py0_s8, px1_s8, py1_s8;
	logic signed [63:0] qx0_s8, qy0_s8, qx1_s8, qy1_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (go_s8) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s8) begin
			car_s8 <= car_s7;
			px0_s8 <= px0_s7;
			py0_s8 <= py0_s7;
			px1_s8 <= px1_s7;
			py1_s8 <= py1_s7;
			qx0_s8 <= 64'(ex0_s7) * 64'(car_s7.nx);
			qy0_s8 <= 64'(ey0_s7) * 64'(car_s7.ny);
			qx1_s8 <= 64'(ex1_s7) * 64'(car_s7.nx);
			qy1_s8 <= 64'(ey1_s7) * 64'(car_s7.ny);
		end
	end

	// stage 9: separations along the normal
	logic signed [64:0] sum_s0, sum_s1;
	logic signed [PX_W-1:0] px0_s9, py0_s9, px1_s9, py1_s9;
	logic signed [SEP_W-1:0] s0_s9, s1_s9;

	always_comb begin
		sum_s0 = 65'(qx0_s8) + 65'(qy0_s8);
		sum_s1 = 65'(qx1_s8) + 65'(qy1_s8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (go_s9) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s9) begin
			car_s9 <= car_s8;
			px0_s9 <= px0_s8;
			py0_s9 <= py0_s8;
			px1_s9 <= px1_s8;
			py1_s9 <= py1_s8;
			s0_s9  <= SEP_W'(sum_s0 >>> FRAC_SH);
			s1_s9  <= SEP_W'(sum_s1 >>> FRAC_SH);
		end
	end

	// stage 10: midpoint offset and separation result
	logic signed [63:0] ra64, rb64, t0, t1;
	logic signed [PX_W-1:0] px0_s10, py0_s10, px1_s10, py1_s10;
	coord_t h0_s10, h1_s10, sep0_s10, sep1_s10;

	always_comb begin
		ra64 = $signed({33'd0, car_s9.ra});
		rb64 = $signed({33'd0, car_s9.rb});
		t0   = ra64 - rb64 - 64'(s0_s9);
		t1   = ra64 - rb64 - 64'(s1_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (go_s10) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s10) begin
			car_s10  <= car_s9;
			px0_s10  <= px0_s9;
			py0_s10  <= py0_s9;
			px1_s10  <= px1_s9;
			py1_s10  <= py1_s9;
			h0_s10   <= sat_full(t0 >>> 1);
			h1_s10   <= sat_full(t1 >>> 1);
			sep0_s10 <= sat_full(64'(s0_s9) - (ra64 + rb64));
			sep1_s10 <= sat_full(64'(s1_s9) - (ra64 + rb64));
		end
	end

	// stage 11: offset products
	logic signed [PX_W-1:0] px0_s11, py0_s11, px1_s11, py1_s11;
	logic signed [63:0] mx0_s11, my0_s11, mx1_s11, my1_s11;
	coord_t sep0_s11, sep1_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (go_s11) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s11) begin
			car_s11  <= car_s10;
			px0_s11  <= px0_s10;
			py0_s11  <= py0_s10;
			px1_s11  <= px1_s10;
			py1_s11  <= py1_s10;
			sep0_s11 <= sep0_s10;
			sep1_s11 <= sep1_s10;
			mx0_s11  <= 64'(h0_s10) * 64'(car_s10.nx);
			my0_s11  <= 64'(h0_s10) * 64'(car_s10.ny);
			mx1_s11  <= 64'(h1_s10) * 64'(car_s10.nx);
			my1_s11  <= 64'(h1_s10) * 64'(car_s10.ny);
		end
	end

	// stage 12: moved points
	coord_t x0_s12, y0_s12, x1_s12, y1_s12, sep0_s12, sep1_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (go_s12) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s12) begin
			car_s12  <= car_s11;
			sep0_s12 <= sep0_s11;
			sep1_s12 <= sep1_s11;
			x0_s12   <= sat_full(64'(px0_s11) + (mx0_s11 >>> FRAC_SH));
			y0_s12   <= sat_full(64'(py0_s11) + (my0_s11 >>> FRAC_SH));
			x1_s12   <= sat_full(64'(px1_s11) + (mx1_s11 >>> FRAC_SH));
			y1_s12   <= sat_full(64'(py1_s11) + (my1_s11 >>> FRAC_SH));
		end
	end

	// output register, lower item then upper item
	logic [63:0] pt0_q, pt1_q;
	coord_t      sep0_q, sep1_q;
	logic [15:0] id0_q, id1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_sel_q   <= 1'b0;
		end else if (go_out) begin
			out_valid_q <= v_s12;
			out_sel_q   <= 1'b0;
		end else if (out_valid_q && !out_stall) begin
			out_sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_out) begin
			pt0_q  <= {x0_s12, y0_s12};
			pt1_q  <= {x1_s12, y1_s12};
			sep0_q <= sep0_s12;
			sep1_q <= sep1_s12;
			id0_q  <= car_s12.lower_id;
			id1_q  <= car_s12.upper_id;
		end
	end

	assign out_valid     = out_valid_q;
	assign contact_point = out_sel_q ? pt1_q : pt0_q;
	assign separation    = out_sel_q ? sep1_q : sep0_q;
	assign contact_id    = out_sel_q ? id1_q : id0_q;
	assign last_point    = out_sel_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_clip_contacts: directed and random segment
// pairs under random idling on both channels, results predicted in Q16.16
// ----------------------------------------------------------------------------

class contact_scoreboard;
	typedef struct {
		logic [63:0] point;
		logic [31:0] sep;
		logic [15:0] id;
		logic        last;
	} contact_t;

	contact_t    pending[$];
	int          errors;
	int          n_pairs;
	int          n_empty;
	int          n_contacts;
	logic [15:0] span_eps;

	function new();
		errors = 0;
		n_pairs = 0;
		n_empty = 0;
		n_contacts = 0;
		span_eps = 16'd1;
	endfunction

	function longint sx(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function longint clampv(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function longint proj(longint dx, longint dy, longint ux, longint uy);
		dx = clampv(dx, -64'sd2147483647, 64'sd2147483647);
		dy = clampv(dy, -64'sd2147483647, 64'sd2147483647);
		return asr(dx * ux + dy * uy, 16);
	endfunction

	function longint ratio_q16(longint num, longint den);
		longint rem;
		longint q;
		q = 0;
		if (num <= 0) return 0;
		if (num >= den) return 65536;
		rem = num;
		for (int i = 0; i < 16; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		return q;
	endfunction

	function void note_pair(logic [63:0] a1, logic [63:0] a2, logic [63:0] b1,
			logic [63:0] b2, logic [63:0] n, logic [30:0] ra_in,
			logic [30:0] rb_in, logic [15:0] id_lo, logic [15:0] id_hi);
		longint a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y, nx, ny, ra, rb;
		longint up1, up2, lo2, span, f, s, h, x, y, sep;
		longint px[2];
		longint py[2];
		logic wide;
		contact_t c;
		a1x = sx(a1[63:32]); a1y = sx(a1[31:0]);
		a2x = sx(a2[63:32]); a2y = sx(a2[31:0]);
		b1x = sx(b1[63:32]); b1y = sx(b1[31:0]);
		b2x = sx(b2[63:32]); b2y = sx(b2[31:0]);
		nx = sx(n[63:32]); ny = sx(n[31:0]);
		ra = ra_in; rb = rb_in;
		n_pairs++;
		up1 = proj(a2x - a1x, a2y - a1y, -ny, nx);
		up2 = proj(b1x - a1x, b1y - a1y, -ny, nx);
		lo2 = proj(b2x - a1x, b2y - a1y, -ny, nx);
		if (up2 < 0 || up1 < lo2) begin
			n_empty++;
			return;
		end
		span = up2 - lo2;
		wide = span > longint'(span_eps);
		px[0] = b2x; py[0] = b2y;
		px[1] = b1x; py[1] = b1y;
		if (lo2 < 0 && wide) begin
			f = ratio_q16(-lo2, span);
			px[0] = b2x + asr((b1x - b2x) * f, 16);
			py[0] = b2y + asr((b1y - b2y) * f, 16);
		end
		if (up2 > up1 && wide) begin
			f = ratio_q16(up1 - lo2, span);
			px[1] = b2x + asr((b1x - b2x) * f, 16);
			py[1] = b2y + asr((b1y - b2y) * f, 16);
		end
		for (int k = 0; k < 2; k++) begin
			s = proj(px[k] - a1x, py[k] - a1y, nx, ny);
			h = clampv(asr(ra - rb - s, 1), -64'sd2147483648, 64'sd2147483647);
			x = clampv(px[k] + asr(h * nx, 16), -64'sd2147483648, 64'sd2147483647);
			y = clampv(py[k] + asr(h * ny, 16), -64'sd2147483648, 64'sd2147483647);
			sep = clampv(s - (ra + rb), -64'sd2147483648, 64'sd2147483647);
			c.point = {x[31:0], y[31:0]};
			c.sep = sep[31:0];
			c.id = k ? id_hi : id_lo;
			c.last = (k == 1);
			pending.push_back(c);
		end
	endfunction

	function void check_contact(logic [63:0] point, logic [31:0] sep, logic [15:0] id,
			logic last);
		contact_t c;
		n_contacts++;
		if (pending.size() == 0) begin
			$display("%t unexpected contact point %h", $realtime, point);
			errors++;
			return;
		end
		c = pending.pop_front();
		if (point !== c.point) begin
			$display("%t contact_point exp %h got %h", $realtime, c.point, point);
			errors++;
		end
		if (sep !== c.sep) begin
			$display("%t separation exp %h got %h", $realtime, c.sep, sep);
			errors++;
		end
		if (id !== c.id) begin
			$display("%t contact_id exp %h got %h", $realtime, c.id, id);
			errors++;
		end
		if (last !== c.last) begin
			$display("%t last_point exp %b got %b", $realtime, c.last, last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import scc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [63:0] ref_start, ref_end, inc_start, inc_end, contact_normal;
	logic [30:0] radius_ref, radius_inc;
	logic [15:0] lower_id, upper_id;
	logic        out_valid, out_stall;
	logic [63:0] contact_point;
	logic signed [31:0] separation;
	logic [15:0] contact_id;
	logic        last_point;

	contact_scoreboard sb;
	bit quiet;

	segment_clip_contacts u_top (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver with random stall bursts
	initial begin
		int burst;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
				if (burst == 0) out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				burst = int'($urandom_range(1, 14));
				out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_contact(contact_point, separation, contact_id, last_point);
	end

	task automatic write_eps(logic [15:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * REG_SPAN_EPS);
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.span_eps = v;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [63:0] pt(int x, int y);
		return {x, y};
	endfunction

	// drive one item; gap before it when allowed
	task automatic send(logic [63:0] a1, logic [63:0] a2, logic [63:0] b1,
			logic [63:0] b2, logic [63:0] n, logic [30:0] ra, logic [30:0] rb,
			logic [15:0] il, logic [15:0] iu);
		if (!quiet && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ref_start <= a1; ref_end <= a2; inc_start <= b1; inc_end <= b2;
		contact_normal <= n; radius_ref <= ra; radius_inc <= rb;
		lower_id <= il; upper_id <= iu;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_pair(a1, a2, b1, b2, n, ra, rb, il, iu);
	endtask

	task automatic idle_in();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int small_coord();
		return int'($urandom_range(0, 20 << 16)) - (10 << 16);
	endfunction

	task automatic send_random();
		int sel;
		logic [63:0] n;
		int ax, ay, len;
		sel = $urandom_range(0, 9);
		n = ($urandom_range(0, 1)) ? pt(0, 32'h10000) :
			($urandom_range(0, 1) ? pt(32'h10000, 0) : pt(32'hb505, 32'hb505));
		if ($urandom_range(0, 1)) n = {-signed'(n[63:32]), -signed'(n[31:0])};
		if (sel < 7) begin
			// well-formed pair: incident roughly facing reference, random overlap
			ax = small_coord(); ay = small_coord(); len = $urandom_range(1, 8 << 16);
			send(pt(ax, ay), pt(ax - int'((len * longint'(signed'(n[31:0]))) >>> 16),
				ay + int'((len * longint'(signed'(n[63:32]))) >>> 16)),
				pt(small_coord(), small_coord()), pt(small_coord(), small_coord()), n,
				31'($urandom_range(0, 3 << 16)), 31'($urandom_range(0, 3 << 16)),
				16'($urandom), 16'($urandom));
		end else if (sel < 9) begin
			send({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, 31'($urandom),
				31'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			send(pt(small_coord(), small_coord()), pt(small_coord(), small_coord()),
				pt(small_coord(), small_coord()), pt(small_coord(), small_coord()),
				{$urandom, $urandom}, 31'($urandom_range(0, 1 << 20)),
				31'($urandom_range(0, 1 << 20)), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		logic [63:0] ny1;
		int unsigned eps_set[5];
		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0;
		ref_start = '0; ref_end = '0; inc_start = '0; inc_end = '0;
		contact_normal = '0; radius_ref = '0; radius_inc = '0;
		lower_id = '0; upper_id = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ny1 = pt(0, 32'h10000);
		// incident inside the reference span, reset epsilon
		send(pt(0, 0), pt(-(4 << 16), 0), pt(-(1 << 16), 1 << 15), pt(-(3 << 16), 1 << 15),
			ny1, 1 << 14, 1 << 13, 16'h0000, 16'hffff);
		// incident end beyond the reference start: no overlap, pair dropped
		send(pt(0, 0), pt(-(2 << 16), 0), pt(1 << 16, -(1 << 14)), pt(-(3 << 16), 1 << 14),
			ny1, 0, 0, 16'h1234, 16'h5678);
		// no overlap on either side
		send(pt(0, 0), pt(-(2 << 16), 0), pt(-(3 << 16), 0), pt(-(5 << 16), 0),
			ny1, 0, 0, 1, 2);
		send(pt(0, 0), pt(-(2 << 16), 0), pt(5 << 16, 0), pt(3 << 16, 0),
			ny1, 0, 0, 3, 4);
		// degenerate incident span
		send(pt(0, 0), pt(-(2 << 16), 0), pt(1 << 16, 0), pt(1 << 16, 0),
			ny1, 0, 0, 5, 6);
		// extremes: coordinates, radii, normal
		send({32'h7fffffff, 32'h80000000}, {32'h80000000, 32'h7fffffff},
			{32'h7fffffff, 32'h7fffffff}, {32'h80000000, 32'h80000000},
			{32'h7fffffff, 32'h80000000}, 31'h7fffffff, 31'h7fffffff, 16'hffff, 0);
		send('0, '1, '1, '0, '1, 0, 31'h7fffffff, 0, 16'hffff);
		send({32'h80000000, 32'h0}, '0, {32'h7fffffff, 32'h80000000}, '1,
			{32'h80000000, 32'h7fffffff}, 31'h7fffffff, 0, 16'haaaa, 16'h5555);
		// non-unit normal
		send(pt(0, 0), pt(-(2 << 16), 0), pt(1 << 16, 1 << 16), pt(-(1 << 16), 1 << 16),
			pt(0, 3 << 16), 1 << 16, 0, 7, 8);
		for (int i = 0; i < 12; i++) send_random();
		idle_in();
		drain();

		eps_set = '{16'd0, 16'hffff, 16'd1, 16'h8000, 16'd300};
		for (int p = 0; p < 5; p++) begin
			write_eps(16'(eps_set[p]));
			for (int i = 0; i < 260; i++) send_random();
			idle_in();
			// hold until everything has come back
			drain();
		end
		write_eps(16'(($urandom_range(0, 65535))));
		quiet = 1'b1;
		for (int i = 0; i < 40; i++) send_random();
		idle_in();

		fork
			drain();
			begin
				repeat (20000) @(posedge clk);
			end
		join_any
		disable fork;
		if (sb.pending.size() != 0) begin
			$display("%t %0d contacts never arrived", $realtime, sb.pending.size());
			sb.errors++;
		end
		$display("%0d segment pairs sent (%0d without overlap), %0d contacts checked",
			sb.n_pairs, sb.n_empty, sb.n_contacts);
		$display("span epsilon swept over zero, reset, midrange and full scale");
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

>>> filelist.f
src/scc_pkg.sv
src/scc_div.sv
src/segment_clip_contacts.sv
sim/tb_top.sv
